// ----- sv/met_pkg.sv -----
`timescale 1ns / 1ps

package met_pkg;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CENTER_REAL,
    REG_CENTER_IMAG,
    REG_PIXEL_STEP,
    REG_ITER_LIMIT
  } met_reg_t;

  // right shift applied to the exact product
  typedef enum logic [1:0] {
    SH_NONE,
    SH_DOUBLE,
    SH_FRAC
  } met_shift_t;

  typedef struct packed {
    logic       start;
    met_shift_t shift;
  } met_mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] value;
  } met_mul_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAPX_GO,
    ST_MAPX_WAIT,
    ST_MAPY_GO,
    ST_MAPY_WAIT,
    ST_TEST,
    ST_MXY_GO,
    ST_MXY_WAIT,
    ST_ZX,
    ST_SQX_GO,
    ST_SQX_WAIT,
    ST_SQY_GO,
    ST_SQY_WAIT,
    ST_FIN
  } met_state_t;

endpackage

// ----- sv/mandelbrot_escape_time_pixel_top.sv -----
`timescale 1ns / 1ps
// One pixel at a time: a new pixel is accepted only once the last one's result has
// been moved into the result register and the sequencer is back in idle.
// Each multiply runs its four partial products on the shared 32x32 multiplier; an
// iteration needs three multiplies plus two add/compare steps.
// Reset (synchronous, rst_n low): idle, no result held, view registers at -0.5,
// 0, 2^FRACTION_BITS/100 and limit 200.
module mandelbrot_escape_time_pixel_top #(
  parameter int ORIGIN_COLUMN = 400,
  parameter int ORIGIN_ROW    = 300,
  parameter int FRACTION_BITS = 56
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [10:0] in_column,
  input  logic [10:0] in_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_inside_res,
  output logic [9:0]  out_iterations,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [63:0] ONE_FIX      = 64'd1 << FRACTION_BITS;
  localparam logic [63:0] CR_RESET     = ~(64'd1 << (FRACTION_BITS - 1)) + 64'd1;
  localparam logic [62:0] STEP_RESET   = 63'(ONE_FIX / 64'd100);
  localparam logic [9:0]  LIMIT_RESET  = 10'd200;
  localparam logic [63:0] ESC_BOUND    = 64'd16 << FRACTION_BITS;
  localparam logic [11:0] ORIG_COL     = 12'(ORIGIN_COLUMN);
  localparam logic [11:0] ORIG_ROW     = 12'(ORIGIN_ROW);

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
    logic signed [64:0] s;
    s = {x[63], x} + {y[63], y};
    if (s[64] != s[63]) return s[64] ? met_pkg::S64_MIN : met_pkg::S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
    logic signed [64:0] s;
    s = {x[63], x} - {y[63], y};
    if (s[64] != s[63]) return s[64] ? met_pkg::S64_MIN : met_pkg::S64_MAX;
    return s[63:0];
  endfunction

  met_pkg::met_state_t   state_r;
  met_pkg::met_state_t   state_nxt;
  met_pkg::met_mul_req_t mul_req;
  met_pkg::met_mul_rsp_t mul_rsp;
  logic signed [63:0]    mul_a;
  logic signed [63:0]    mul_b;

  logic signed [63:0] center_real_r;
  logic signed [63:0] center_imag_r;
  logic [62:0]        pixel_step_r;
  logic [9:0]         iter_limit_r;

  logic [11:0]        off_x_r;
  logic [11:0]        off_y_r;
  logic signed [63:0] cx_r;
  logic signed [63:0] cy_r;
  logic signed [63:0] zx_r;
  logic signed [63:0] zy_r;
  logic signed [63:0] zx2_r;
  logic signed [63:0] zy2_r;
  logic signed [63:0] u_r;
  logic [9:0]         count_r;

  logic        out_valid_r;
  logic        out_inside_r;
  logic [9:0]  out_iter_r;
  logic [7:0]  out_red_r;
  logic [7:0]  out_green_r;
  logic [7:0]  out_blue_r;

  logic        in_accept;
  logic        out_free;
  logic [63:0] mag_sum;
  logic        go_on;
  logic        in_set;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  // both squares are non-negative, so the sum fits in 64 bits
  assign mag_sum   = 64'(zx2_r) + 64'(zy2_r);
  assign go_on     = (mag_sum <= ESC_BOUND) && (count_r < iter_limit_r);
  assign in_set    = (count_r == iter_limit_r);

  met_mul #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .a    (mul_a),
    .b    (mul_b),
    .rsp  (mul_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      met_pkg::ST_IDLE:      if (in_accept) state_nxt = met_pkg::ST_MAPX_GO;
      met_pkg::ST_MAPX_GO:   state_nxt = met_pkg::ST_MAPX_WAIT;
      met_pkg::ST_MAPX_WAIT: if (mul_rsp.done) state_nxt = met_pkg::ST_MAPY_GO;
      met_pkg::ST_MAPY_GO:   state_nxt = met_pkg::ST_MAPY_WAIT;
      met_pkg::ST_MAPY_WAIT: if (mul_rsp.done) state_nxt = met_pkg::ST_TEST;
      met_pkg::ST_TEST:      state_nxt = go_on ? met_pkg::ST_MXY_GO : met_pkg::ST_FIN;
      met_pkg::ST_MXY_GO:    state_nxt = met_pkg::ST_MXY_WAIT;
      met_pkg::ST_MXY_WAIT:  if (mul_rsp.done) state_nxt = met_pkg::ST_ZX;
      met_pkg::ST_ZX:        state_nxt = met_pkg::ST_SQX_GO;
      met_pkg::ST_SQX_GO:    state_nxt = met_pkg::ST_SQX_WAIT;
      met_pkg::ST_SQX_WAIT:  if (mul_rsp.done) state_nxt = met_pkg::ST_SQY_GO;
      met_pkg::ST_SQY_GO:    state_nxt = met_pkg::ST_SQY_WAIT;
      met_pkg::ST_SQY_WAIT:  if (mul_rsp.done) state_nxt = met_pkg::ST_TEST;
      met_pkg::ST_FIN:       if (out_free) state_nxt = met_pkg::ST_IDLE;
      default:               state_nxt = met_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall      = (state_r != met_pkg::ST_IDLE);
    mul_req.start = 1'b0;
    mul_req.shift = met_pkg::SH_NONE;
    mul_a         = zx_r;
    mul_b         = zy_r;
    unique case (state_r)
      met_pkg::ST_MAPX_GO: begin
        mul_req.start = 1'b1;
        mul_a         = {{52{off_x_r[11]}}, off_x_r};
        mul_b         = {1'b0, pixel_step_r};
      end
      met_pkg::ST_MAPY_GO: begin
        mul_req.start = 1'b1;
        mul_a         = {{52{off_y_r[11]}}, off_y_r};
        mul_b         = {1'b0, pixel_step_r};
      end
      met_pkg::ST_MXY_GO: begin
        mul_req.start = 1'b1;
        mul_req.shift = met_pkg::SH_DOUBLE;
      end
      met_pkg::ST_SQX_GO: begin
        mul_req.start = 1'b1;
        mul_req.shift = met_pkg::SH_FRAC;
        mul_b         = zx_r;
      end
      met_pkg::ST_SQY_GO: begin
        mul_req.start = 1'b1;
        mul_req.shift = met_pkg::SH_FRAC;
        mul_a         = zy_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= met_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_real_r <= CR_RESET;
      center_imag_r <= '0;
      pixel_step_r  <= STEP_RESET;
      iter_limit_r  <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        met_pkg::REG_CENTER_REAL: center_real_r <= cfg_data;
        met_pkg::REG_CENTER_IMAG: center_imag_r <= cfg_data;
        met_pkg::REG_PIXEL_STEP:  pixel_step_r  <= cfg_data[62:0];
        met_pkg::REG_ITER_LIMIT:  iter_limit_r  <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      off_x_r <= {1'b0, in_column} - ORIG_COL;
      off_y_r <= {1'b0, in_row} - ORIG_ROW;
    end
    unique case (state_r)
      met_pkg::ST_MAPX_WAIT: begin
        if (mul_rsp.done) cx_r <= sat_add(mul_rsp.value, center_real_r);
      end
      met_pkg::ST_MAPY_WAIT: begin
        if (mul_rsp.done) begin
          cy_r    <= sat_add(mul_rsp.value, center_imag_r);
          zx_r    <= '0;
          zy_r    <= '0;
          zx2_r   <= '0;
          zy2_r   <= '0;
          count_r <= '0;
        end
      end
      met_pkg::ST_MXY_WAIT: begin
        if (mul_rsp.done) begin
          zy_r <= sat_add(mul_rsp.value, cy_r);
          u_r  <= sat_sub(zx2_r, zy2_r);
        end
      end
      met_pkg::ST_ZX: zx_r <= sat_add(u_r, cx_r);
      met_pkg::ST_SQX_WAIT: begin
        if (mul_rsp.done) zx2_r <= mul_rsp.value;
      end
      met_pkg::ST_SQY_WAIT: begin
        if (mul_rsp.done) begin
          zy2_r   <= mul_rsp.value;
          count_r <= count_r + 10'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // result register: frees the input side while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == met_pkg::ST_FIN) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == met_pkg::ST_FIN) && out_free) begin
      out_inside_r <= in_set;
      out_iter_r   <= count_r;
      out_red_r    <= in_set ? 8'd0 : 8'(count_r[7:0] * 8'd3);
      out_green_r  <= in_set ? 8'd0 : 8'(count_r[7:0] * 8'd7);
      out_blue_r   <= in_set ? 8'd0 : 8'(count_r[7:0] * 8'd13);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_iterations = out_iter_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;

endmodule

// ----- sv/met_mul.sv -----
`timescale 1ns / 1ps

// Signed 64x64 fixed-point multiply: four 32x32 partial products, one per
// cycle, summed into a 128-bit accumulator, then shifted and saturated.
module met_mul #(
  parameter int FRACTION_BITS = 56
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  met_pkg::met_mul_req_t req,
  input  logic signed [63:0]    a,
  input  logic signed [63:0]    b,
  output met_pkg::met_mul_rsp_t rsp
);

  logic               busy_r;
  logic [2:0]         cnt_r;
  logic               done_r;
  logic               pp_vld_r;
  logic [63:0]        a_mag_r;
  logic [63:0]        b_mag_r;
  logic               neg_r;
  met_pkg::met_shift_t shift_r;
  logic [63:0]        pp_r;
  logic [1:0]         pp_off_r;
  logic [127:0]       acc_r;
  logic signed [63:0] res_r;

  logic [31:0]        a_half;
  logic [31:0]        b_half;
  logic [63:0]        prod;
  logic [127:0]       term;
  logic [127:0]       q;
  logic               ovf;
  logic signed [63:0] sat;

  assign a_half = cnt_r[0] ? a_mag_r[63:32] : a_mag_r[31:0];
  assign b_half = cnt_r[1] ? b_mag_r[63:32] : b_mag_r[31:0];
  assign prod   = {32'b0, a_half} * {32'b0, b_half};

  always_comb begin
    unique case (pp_off_r)
      2'd0:    term = {64'b0, pp_r};
      2'd1:    term = {32'b0, pp_r, 32'b0};
      2'd2:    term = {pp_r, 64'b0};
      default: term = '0;
    endcase
  end

  always_comb begin
    unique case (shift_r)
      met_pkg::SH_NONE:   q = acc_r;
      met_pkg::SH_DOUBLE: q = acc_r >> (FRACTION_BITS - 1);
      met_pkg::SH_FRAC:   q = acc_r >> FRACTION_BITS;
      default:            q = acc_r;
    endcase
  end

  assign ovf = (q[127:64] != 64'b0) || q[63];

  always_comb begin
    if (neg_r) begin
      sat = ovf ? met_pkg::S64_MIN : -$signed(q[63:0]);
    end else begin
      sat = ovf ? met_pkg::S64_MAX : $signed(q[63:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      done_r   <= 1'b0;
      pp_vld_r <= 1'b0;
    end else begin
      done_r   <= 1'b0;
      pp_vld_r <= busy_r && (cnt_r < 3'd4);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_mag_r <= a[63] ? 64'(-a) : 64'(a);
      b_mag_r <= b[63] ? 64'(-b) : 64'(b);
      neg_r   <= a[63] ^ b[63];
      shift_r <= req.shift;
      acc_r   <= '0;
    end
    if (busy_r && (cnt_r < 3'd4)) begin
      pp_r     <= prod;
      pp_off_r <= {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
    end
    if (pp_vld_r) begin
      acc_r <= acc_r + term;
    end
    if (busy_r && (cnt_r == 3'd5)) begin
      res_r <= sat;
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule

// ----- sv/met_check.sv -----
`timescale 1ns / 1ps

module met_check (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_inside_res,
  input logic [9:0] out_iterations,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is in work");

  a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_res |-> (out_red == 8'd0) && (out_green == 8'd0) &&
                                    (out_blue == 8'd0))
    else $error("inside pixel not black");

  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inside_res |->
      (out_red == 8'(out_iterations[7:0] * 8'd3)) &&
      (out_green == 8'(out_iterations[7:0] * 8'd7)) &&
      (out_blue == 8'(out_iterations[7:0] * 8'd13)))
    else $error("color does not match iteration count");

endmodule

bind mandelbrot_escape_time_pixel_top met_check u_met_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_inside_res(out_inside_res),
  .out_iterations(out_iterations),
  .out_red       (out_red),
  .out_green     (out_green),
  .out_blue      (out_blue)
);
